>>> rtl/tcs_pkg.sv
// Shared types and constants of the text console cursor and scroll core.
// Used by tcs_cursor, the top level and the testbench; depends on nothing.
package tcs_pkg;

    localparam int COLUMNS      = 128;
    localparam int SCREEN_CELLS = 4096;
    localparam int ROWS         = SCREEN_CELLS / COLUMNS;

    localparam int CUR_W  = $clog2(SCREEN_CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CHAR_W = 8;

    localparam logic [CUR_W-1:0] HOME_CELL  = CUR_W'(SCREEN_CELLS - 2 * COLUMNS);
    localparam logic [CUR_W:0]   LAST_START = (CUR_W + 1)'(SCREEN_CELLS - COLUMNS);

    localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_DEL   = 8'd127;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
        logic [CUR_W-1:0]  cell_address;
    } t_in_item;

    typedef struct packed {
        logic [CUR_W-1:0]  cursor_position;
        logic [CHAR_W-1:0] cell_value;
        logic              scrolled;
    } t_out_item;

    typedef struct packed {
        logic [CUR_W-1:0] next_cursor;
        logic             store;
        logic             scroll;
    } t_put_res;

endpackage

>>> rtl/tcs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tcs_cursor.sv
// Next-cursor logic for a put item: control codes, store decision and scroll detect.
// Depends on tcs_pkg.
module tcs_cursor
    import tcs_pkg::*;
(
    input  logic [CUR_W-1:0]  i_cursor,
    input  logic [CHAR_W-1:0] i_code,
    output t_put_res          o_res
);

    logic [CUR_W:0]   w_ext;
    logic [CUR_W:0]   w_line;
    logic [CUR_W:0]   w_next;
    logic [COL_W-1:0] w_col;
    logic             w_store;
    logic             w_scroll;

    always_comb begin
        w_ext   = {1'b0, i_cursor};
        w_col   = i_cursor[COL_W-1:0];
        w_line  = {1'b0, i_cursor[CUR_W-1:COL_W], {COL_W{1'b0}}};
        w_store = 1'b0;
        priority if (i_code == CODE_BS || i_code == CODE_DEL) begin
            w_next = (w_col != '0) ? w_ext - (CUR_W + 1)'(1) : w_ext;
        end else if (i_code == CODE_CR) begin
            w_next = w_line;
        end else if (i_code == CODE_LF) begin
            w_next = w_line + (CUR_W + 1)'(COLUMNS);
        end else begin
            w_next  = w_ext + (CUR_W + 1)'(1);
            w_store = 1'b1;
        end
        w_scroll = (w_next >= LAST_START);
    end

    assign o_res.next_cursor = w_scroll ? HOME_CELL : w_next[CUR_W-1:0];
    assign o_res.store       = w_store;
    assign o_res.scroll      = w_scroll;

endmodule

>>> rtl/text_console_cursor_scroll_core.sv
// Top level of the text console cursor and scroll core: control sequencer and screen store.
// Depends on tcs_pkg, tcs_ram and tcs_cursor.
//
//   channel | direction | handshake                 | payload
//   in      | into core | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   out     | from core | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// A read item passes through S_EXEC, S_FETCH and S_HOLD to the output register, a plain put through S_EXEC and S_HOLD.
// A put that scrolls also blanks the new bottom row, one cell at a time.
// Scrolling moves a row offset register, so the screen RAM is never copied.
// After reset a clearing pass writes spaces to all SCREEN_CELLS cells while o_in_stall is high.
// The output register holds a finished item while the consumer stalls.
module text_console_cursor_scroll_core
    import tcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_HOLD   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CUR_W-1:0] r_cnt, n_cnt;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [ROW_W-1:0] r_top, n_top;
    logic [ROW_W-1:0] r_clr_row, n_clr_row;
    t_in_item         r_item, n_item;
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_put_res          w_put;
    logic              w_we;
    logic [CUR_W-1:0]  w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic              w_re;
    logic [CUR_W-1:0]  w_raddr;
    logic [CHAR_W-1:0] w_rdata;
    logic              w_out_free;

    tcs_cursor u_cursor (
        .i_cursor (r_cursor),
        .i_code   (r_item.char_code),
        .o_res    (w_put)
    );

    tcs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (SCREEN_CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_raddr    = {r_item.cell_address[CUR_W-1:COL_W] + r_top,
                         r_item.cell_address[COL_W-1:0]};
    assign w_re       = (r_state == S_EXEC) && (r_item.action == ACT_READ);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cursor    = r_cursor;
        n_top       = r_top;
        n_clr_row   = r_clr_row;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = r_cnt;
        w_wdata     = CODE_SPACE;
        unique case (r_state)
            S_INIT: begin
                w_we  = 1'b1;
                n_cnt = r_cnt + CUR_W'(1);
                if (r_cnt == CUR_W'(SCREEN_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.action == ACT_READ) begin
                    n_state = S_FETCH;
                end else begin
                    w_we    = w_put.store;
                    w_waddr = {r_cursor[CUR_W-1:COL_W] + r_top, r_cursor[COL_W-1:0]};
                    w_wdata = r_item.char_code;
                    n_cursor              = w_put.next_cursor;
                    n_res.cursor_position = w_put.next_cursor;
                    n_res.cell_value      = '0;
                    n_res.scrolled        = w_put.scroll;
                    if (w_put.scroll) begin
                        n_top     = r_top + ROW_W'(1);
                        n_clr_row = r_top;
                        n_cnt     = '0;
                        n_state   = S_SCROLL;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_FETCH: begin
                n_res.cursor_position = r_cursor;
                n_res.cell_value      = w_rdata;
                n_res.scrolled        = 1'b0;
                n_state               = S_HOLD;
            end
            S_SCROLL: begin
                w_we    = 1'b1;
                w_waddr = {r_clr_row, r_cnt[COL_W-1:0]};
                n_cnt   = r_cnt + CUR_W'(1);
                if (r_cnt[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_cursor    <= HOME_CELL;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cursor    <= n_cursor;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
        r_clr_row <= n_clr_row;
        r_item    <= n_item;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> test/text_console_cursor_scroll_core_tb.sv
// Testbench of the text console cursor and scroll core: control codes, line wrap,
// random text with reads and output backpressure, all checked against a local screen copy.
// Depends on tcs_pkg and text_console_cursor_scroll_core.
module text_console_cursor_scroll_core_tb
    import tcs_pkg::*;
;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    logic [CHAR_W-1:0] screen_copy [SCREEN_CELLS];
    logic [CUR_W-1:0]  cursor_copy;
    t_out_item         expected_cells [$];

    int error_count  = 0;
    int put_count    = 0;
    int read_count   = 0;
    int scroll_count = 0;
    int result_count = 0;
    int hold_cycles  = 0;
    bit gaps_on      = 1'b1;

    text_console_cursor_scroll_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_in_item make_item(input logic act, input logic [CHAR_W-1:0] code,
                                           input logic [CUR_W-1:0] addr);
        t_in_item item;
        item.action       = act;
        item.char_code    = code;
        item.cell_address = addr;
        return item;
    endfunction

    // Applies one item to the screen copy and returns the result it should produce.
    function automatic t_out_item console_step(input t_in_item item);
        t_out_item res;
        int        c;
        int        col;
        res = '0;
        c   = cursor_copy;
        col = c % COLUMNS;
        if (item.action == ACT_READ) begin
            res.cell_value = screen_copy[item.cell_address % SCREEN_CELLS];
            read_count++;
        end else begin
            put_count++;
            if (item.char_code == CODE_BS || item.char_code == CODE_DEL) begin
                if (col != 0) c = c - 1;
            end else if (item.char_code == CODE_CR) begin
                c = c - col;
            end else if (item.char_code == CODE_LF) begin
                c = c - col + COLUMNS;
            end else begin
                screen_copy[c % SCREEN_CELLS] = item.char_code;
                c = c + 1;
            end
            if (c >= SCREEN_CELLS - COLUMNS) begin
                for (int k = 0; k < SCREEN_CELLS - COLUMNS; k++) begin
                    screen_copy[k] = screen_copy[k + COLUMNS];
                end
                for (int k = SCREEN_CELLS - COLUMNS; k < SCREEN_CELLS; k++) begin
                    screen_copy[k] = CODE_SPACE;
                end
                c            = HOME_CELL;
                res.scrolled = 1'b1;
                scroll_count++;
            end
            cursor_copy = CUR_W'(c);
        end
        res.cursor_position = cursor_copy;
        return res;
    endfunction

    task automatic send_item(input t_in_item item);
        while (gaps_on && $urandom_range(0, 99) < 10) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_cells.push_back(console_step(item));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (COLUMNS + 16) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_put(input logic [CHAR_W-1:0] code);
        send_item(make_item(ACT_PUT, code, CUR_W'($urandom_range(0, SCREEN_CELLS - 1))));
    endtask

    task automatic send_read(input logic [CUR_W-1:0] addr);
        send_item(make_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), addr));
    endtask

    // Extreme field values, every control code, backspace at column 0 and a scroll on line feed.
    task automatic test_control_codes();
        send_read('0);
        send_read({CUR_W{1'b1}});
        send_item(make_item(ACT_READ, {CHAR_W{1'b1}}, 12'hAAA));
        send_item(make_item(ACT_READ, '0, 12'h555));
        send_item(make_item(ACT_PUT, 8'h41, {CUR_W{1'b1}}));
        send_item(make_item(ACT_PUT, '0, '0));
        send_put({CHAR_W{1'b1}});
        send_read(HOME_CELL);
        send_put(CODE_BS);
        send_put(CODE_DEL);
        send_put(CODE_CR);
        send_put(CODE_CR);
        send_put(CODE_BS);
        send_put(CODE_DEL);
        send_put(8'h78);
        send_put(CODE_LF);
        send_read(CUR_W'(HOME_CELL - COLUMNS));
        send_read(CUR_W'(HOME_CELL - COLUMNS + 1));
        send_read(CUR_W'(HOME_CELL + COLUMNS));
        send_put(CODE_LF);
        send_read({CUR_W{1'b1}});
        wait_drained();
    endtask

    // A full line of text wraps the cursor into the last row and scrolls the screen.
    task automatic test_line_wrap();
        for (int n = 0; n < COLUMNS + 2; n++) begin
            send_put(CHAR_W'($urandom_range(8'h21, 8'h7E)));
        end
        for (int n = 0; n < 12; n++) begin
            send_read(CUR_W'($urandom_range(HOME_CELL - COLUMNS, SCREEN_CELLS - 1)));
        end
        wait_drained();
    endtask

    task automatic test_random_text(input int count, input bit with_gaps);
        int pick;
        gaps_on = with_gaps;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                if ($urandom_range(0, 1) == 1)
                    send_read(CUR_W'($urandom_range(SCREEN_CELLS - 4 * COLUMNS,
                                                    SCREEN_CELLS - 1)));
                else
                    send_read(CUR_W'($urandom_range(0, SCREEN_CELLS - 1)));
            end else if (pick < 33) begin
                send_put(CODE_LF);
            end else if (pick < 37) begin
                send_put(CODE_CR);
            end else if (pick < 42) begin
                send_put($urandom_range(0, 1) == 1 ? CODE_BS : CODE_DEL);
            end else if (pick < 50) begin
                send_put(CHAR_W'($urandom_range(0, 255)));
            end else begin
                send_put(CHAR_W'($urandom_range(8'h20, 8'h7E)));
            end
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // The receiver holds off while items keep coming, so the core must stall its input.
    task automatic test_output_backpressure();
        gaps_on     = 1'b0;
        hold_cycles = 300;
        for (int n = 0; n < 60; n++) begin
            if (n % 3 == 0)
                send_read(CUR_W'($urandom_range(SCREEN_CELLS - 4 * COLUMNS, SCREEN_CELLS - 1)));
            else if (n % 17 == 0)
                send_put(CODE_LF);
            else
                send_put(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall = 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall = gaps_on && ($urandom_range(0, 99) < 10);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (expected_cells.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result item %h", $time, o_out_item);
            end else begin
                want = expected_cells.pop_front();
                if (o_out_item.cursor_position !== want.cursor_position) begin
                    error_count++;
                    $display("%0t: cursor_position expected %0d actual %0d", $time,
                             want.cursor_position, o_out_item.cursor_position);
                end
                if (o_out_item.cell_value !== want.cell_value) begin
                    error_count++;
                    $display("%0t: cell_value expected %h actual %h", $time,
                             want.cell_value, o_out_item.cell_value);
                end
                if (o_out_item.scrolled !== want.scrolled) begin
                    error_count++;
                    $display("%0t: scrolled expected %0d actual %0d", $time,
                             want.scrolled, o_out_item.scrolled);
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < SCREEN_CELLS; k++) screen_copy[k] = CODE_SPACE;
        cursor_copy = HOME_CELL;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_control_codes();
        test_line_wrap();
        test_random_text(150, 1'b0);
        test_random_text(550, 1'b1);
        test_output_backpressure();

        $display("Checked %0d results: %0d puts, %0d reads, %0d scrolls.",
                 result_count, put_count, read_count, scroll_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
